// ===== hdl/tac_pkg.sv =====
// Shared types, codes and the microcode program of the accumulator core.
// Depends on nothing; the top level, the sequencer and the datapath import it.
package tac_pkg;

  localparam logic [1:0] CMD_WR = 2'd0;
  localparam logic [1:0] CMD_RD = 2'd1;
  localparam logic [1:0] CMD_EX = 2'd2;

  localparam logic [7:0] OP_LDA  = 8'h00;
  localparam logic [7:0] OP_MOV  = 8'h01;
  localparam logic [7:0] OP_LDC  = 8'h06;
  localparam logic [7:0] OP_PSHA = 8'h38;
  localparam logic [7:0] OP_PSHC = 8'h39;
  localparam logic [7:0] OP_POP  = 8'h41;
  localparam logic [7:0] OP_ADD  = 8'h48;
  localparam logic [7:0] OP_JMP  = 8'h78;
  localparam logic [7:0] OP_HLT  = 8'hFF;

  localparam logic [15:0] SP_RESET = 16'h00FF;

  typedef logic [4:0] upc_t;

  localparam upc_t UA_WR    = 5'd0;
  localparam upc_t UA_RD0   = 5'd1;
  localparam upc_t UA_RD1   = 5'd2;
  localparam upc_t UA_EX0   = 5'd3;
  localparam upc_t UA_EX1   = 5'd4;
  localparam upc_t UA_LDA0  = 5'd5;
  localparam upc_t UA_LDA1  = 5'd6;
  localparam upc_t UA_MOV   = 5'd7;
  localparam upc_t UA_LDC0  = 5'd8;
  localparam upc_t UA_LDC1  = 5'd9;
  localparam upc_t UA_PSHA  = 5'd10;
  localparam upc_t UA_PSHC  = 5'd11;
  localparam upc_t UA_POP0  = 5'd12;
  localparam upc_t UA_POP1  = 5'd13;
  localparam upc_t UA_POP2  = 5'd14;
  localparam upc_t UA_ADD   = 5'd15;
  localparam upc_t UA_JMP0  = 5'd16;
  localparam upc_t UA_JMP1  = 5'd17;
  localparam upc_t UA_JMP2  = 5'd18;
  localparam upc_t UA_HLT   = 5'd19;
  localparam upc_t UA_UNK   = 5'd20;
  localparam upc_t UA_IDLE  = 5'd21;

  typedef enum logic [1:0] {AS_CMD, AS_PC, AS_SP} asel_t;
  typedef enum logic [1:0] {WD_CMD, WD_A, WD_C} wsel_t;
  typedef enum logic [3:0] {
    ALU_NONE, ALU_LDA_MEM, ALU_LDA_C, ALU_ADD, ALU_LDC_MEM,
    ALU_LO, ALU_JMP, ALU_RD, ALU_HALT, ALU_UNK
  } aluop_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_DISP, SEQ_DONE} seq_t;

  typedef struct packed {
    asel_t  addr_sel;
    wsel_t  wd_sel;
    logic   mem_rd;
    logic   mem_wr;
    logic   pc_inc;
    logic   sp_inc;
    logic   sp_dec;
    aluop_t op;
    seq_t   seq;
  } ucw_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic [7:0]  acc;
    logic [7:0]  c;
    logic [15:0] pc;
    logic [15:0] sp;
    logic        carry;
    logic        ovf;
    logic        sign;
    logic        zero;
    logic        halted;
    logic        unk;
  } arch_t;

  localparam ucw_t UCW_NOP = '{AS_CMD, WD_CMD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                               ALU_NONE, SEQ_NEXT};

  function automatic ucw_t ucode(input upc_t a);
    ucw_t w;
    w = UCW_NOP;
    unique case (a)
      UA_WR: begin
        w.mem_wr = 1'b1;
        w.seq = SEQ_DONE;
      end
      UA_RD0: begin
        w.mem_rd = 1'b1;
      end
      UA_RD1: begin
        w.op = ALU_RD;
        w.seq = SEQ_DONE;
      end
      UA_EX0, UA_LDA0, UA_LDC0, UA_JMP0: begin
        w.addr_sel = AS_PC;
        w.mem_rd = 1'b1;
        w.pc_inc = 1'b1;
      end
      UA_EX1: begin
        w.seq = SEQ_DISP;
      end
      UA_LDA1, UA_POP2: begin
        w.op = ALU_LDA_MEM;
        w.seq = SEQ_DONE;
      end
      UA_MOV: begin
        w.op = ALU_LDA_C;
        w.seq = SEQ_DONE;
      end
      UA_LDC1: begin
        w.op = ALU_LDC_MEM;
        w.seq = SEQ_DONE;
      end
      UA_PSHA: begin
        w.addr_sel = AS_SP;
        w.wd_sel = WD_A;
        w.mem_wr = 1'b1;
        w.sp_dec = 1'b1;
        w.seq = SEQ_DONE;
      end
      UA_PSHC: begin
        w.addr_sel = AS_SP;
        w.wd_sel = WD_C;
        w.mem_wr = 1'b1;
        w.sp_dec = 1'b1;
        w.seq = SEQ_DONE;
      end
      UA_POP0: begin
        w.sp_inc = 1'b1;
      end
      UA_POP1: begin
        w.addr_sel = AS_SP;
        w.mem_rd = 1'b1;
      end
      UA_ADD: begin
        w.op = ALU_ADD;
        w.seq = SEQ_DONE;
      end
      UA_JMP1: begin
        w.addr_sel = AS_PC;
        w.mem_rd = 1'b1;
        w.pc_inc = 1'b1;
        w.op = ALU_LO;
      end
      UA_JMP2: begin
        w.op = ALU_JMP;
        w.seq = SEQ_DONE;
      end
      UA_HLT: begin
        w.op = ALU_HALT;
        w.seq = SEQ_DONE;
      end
      UA_UNK: begin
        w.op = ALU_UNK;
        w.seq = SEQ_DONE;
      end
      default: begin
        w.seq = SEQ_DONE;
      end
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(input logic [7:0] op);
    upc_t a;
    unique case (op)
      OP_LDA:  a = UA_LDA0;
      OP_MOV:  a = UA_MOV;
      OP_LDC:  a = UA_LDC0;
      OP_PSHA: a = UA_PSHA;
      OP_PSHC: a = UA_PSHC;
      OP_POP:  a = UA_POP0;
      OP_ADD:  a = UA_ADD;
      OP_JMP:  a = UA_JMP0;
      OP_HLT:  a = UA_HLT;
      default: a = UA_UNK;
    endcase
    return a;
  endfunction

  function automatic upc_t entry(input logic [1:0] cmd, input logic halted);
    upc_t a;
    unique case (cmd)
      CMD_WR:  a = UA_WR;
      CMD_RD:  a = UA_RD0;
      CMD_EX:  a = halted ? UA_IDLE : UA_EX0;
      default: a = UA_IDLE;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/tiny_accumulator_cpu_core.sv =====
// Top level of the accumulator core: memory, sequencer, datapath, result register.
// Each command runs as a sequence of microcode steps; execute ends at once when halted
// and otherwise makes up to three sequential reads of the single-port memory.
// One command at a time: no word is accepted while a command is busy, and a waiting result
// stalls the core at its last step. After reset a clearing pass writes zero to all
// 2**MEM_ADDR_BITS bytes, one per cycle, with in_ready low; pc 0, sp 0xFF, the rest 0.
module tiny_accumulator_cpu_core #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_acc_value,
  output logic [7:0]  out_c_value,
  output logic [15:0] out_program_counter,
  output logic [15:0] out_stack_pointer,
  output logic        out_carry_flag,
  output logic        out_overflow_flag,
  output logic        out_sign_flag,
  output logic        out_zero_flag,
  output logic        out_halted,
  output logic        out_unknown_opcode
);
  import tac_pkg::*;

  logic                     clearing_r;
  logic [MEM_ADDR_BITS-1:0] clr_addr_r;
  logic                     out_valid_r;
  arch_t                    out_r;

  ucw_t        cw;
  logic        busy, start, step_en, done;
  arch_t       arch_q, arch_nxt;
  logic [15:0] dp_addr;
  logic [7:0]  dp_wdata, rdata;
  logic        dp_we, dp_re;

  logic                     m_we;
  logic [MEM_ADDR_BITS-1:0] m_addr;
  logic [7:0]               m_wdata;

  assign in_ready = !clearing_r && !busy;
  assign start = in_valid && in_ready;
  assign step_en = !(cw.seq == SEQ_DONE && out_valid_r && !out_ready);
  assign done = busy && step_en && (cw.seq == SEQ_DONE);

  assign m_we = clearing_r | dp_we;
  assign m_addr = clearing_r ? clr_addr_r : dp_addr[MEM_ADDR_BITS-1:0];
  assign m_wdata = clearing_r ? 8'h00 : dp_wdata;

  tac_mem #(.AW(MEM_ADDR_BITS)) u_mem (
    .clk   (clk),
    .we    (m_we),
    .re    (dp_re),
    .addr  (m_addr),
    .wdata (m_wdata),
    .rdata (rdata)
  );

  tac_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cmd     (in_command),
    .halted  (arch_q.halted),
    .opcode  (rdata),
    .step_en (step_en),
    .cw      (cw),
    .busy    (busy)
  );

  tac_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cmd_address (in_address),
    .cmd_wdata   (in_write_data),
    .cw          (cw),
    .step_en     (step_en),
    .rdata       (rdata),
    .mem_addr    (dp_addr),
    .mem_wdata   (dp_wdata),
    .mem_we      (dp_we),
    .mem_re      (dp_re),
    .arch_q      (arch_q),
    .arch_nxt    (arch_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clearing_r <= 1'b0;
        end
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= arch_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_read_data = out_r.rd;
  assign out_acc_value = out_r.acc;
  assign out_c_value = out_r.c;
  assign out_program_counter = out_r.pc;
  assign out_stack_pointer = out_r.sp;
  assign out_carry_flag = out_r.carry;
  assign out_overflow_flag = out_r.ovf;
  assign out_sign_flag = out_r.sign;
  assign out_zero_flag = out_r.zero;
  assign out_halted = out_r.halted;
  assign out_unknown_opcode = out_r.unk;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy && !clearing_r)
    else $error("command accepted while core busy or clearing");

  a_no_result_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !out_valid_r && !busy)
    else $error("activity during memory clearing pass");

  a_halt_freezes_pc: assert property (@(posedge clk) disable iff (!rst_n)
    arch_q.halted |=> arch_q.halted && $stable(arch_q.pc))
    else $error("program counter moved after halt");

  a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !out_valid_r || out_ready)
    else $error("result overwrote a pending word");

endmodule

// ===== hdl/tac_mem.sv =====
// Single-port byte memory with a registered read port.
// Depends on nothing but its address width parameter.
module tac_mem #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [2**AW];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tac_useq.sv =====
// Microcode sequencer: step counter, program table and opcode dispatch.
// Depends on tac_pkg for the control word and the program.
module tac_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    cmd,
  input  logic          halted,
  input  logic [7:0]    opcode,
  input  logic          step_en,
  output tac_pkg::ucw_t cw,
  output logic          busy
);
  import tac_pkg::*;

  upc_t upc_r, upc_nxt;
  logic busy_r, busy_nxt;

  assign cw = busy_r ? ucode(upc_r) : UCW_NOP;
  assign busy = busy_r;

  always_comb begin
    upc_nxt = upc_r;
    busy_nxt = busy_r;
    if (start) begin
      upc_nxt = entry(cmd, halted);
      busy_nxt = 1'b1;
    end else if (busy_r && step_en) begin
      unique case (cw.seq)
        SEQ_NEXT: upc_nxt = upc_r + 5'd1;
        SEQ_DISP: upc_nxt = dispatch(opcode);
        SEQ_DONE: busy_nxt = 1'b0;
        default:  busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
      busy_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== hdl/tac_dp.sv =====
// Datapath of the core: registers, flags, adder and memory address selection.
// Depends on tac_pkg; it is driven by the control word of tac_useq.
module tac_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [15:0]    cmd_address,
  input  logic [7:0]     cmd_wdata,
  input  tac_pkg::ucw_t  cw,
  input  logic           step_en,
  input  logic [7:0]     rdata,
  output logic [15:0]    mem_addr,
  output logic [7:0]     mem_wdata,
  output logic           mem_we,
  output logic           mem_re,
  output tac_pkg::arch_t arch_q,
  output tac_pkg::arch_t arch_nxt
);
  import tac_pkg::*;

  arch_t       arch_r;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] addr_r;
  logic [7:0]  wd_r;
  logic [8:0]  sum;
  logic [7:0]  a_new;
  logic        a_upd;

  assign arch_q = arch_r;
  assign sum = {1'b0, arch_r.acc} + {1'b0, arch_r.c};
  assign mem_we = cw.mem_wr & step_en;
  assign mem_re = cw.mem_rd & step_en;

  always_comb begin
    unique case (cw.addr_sel)
      AS_PC:   mem_addr = arch_r.pc;
      AS_SP:   mem_addr = arch_r.sp;
      default: mem_addr = addr_r;
    endcase
    unique case (cw.wd_sel)
      WD_A:    mem_wdata = arch_r.acc;
      WD_C:    mem_wdata = arch_r.c;
      default: mem_wdata = wd_r;
    endcase
  end

  always_comb begin
    arch_nxt = arch_r;
    lo_nxt = lo_r;
    a_new = arch_r.acc;
    a_upd = 1'b0;
    if (start) begin
      arch_nxt.rd = 8'h00;
      arch_nxt.unk = 1'b0;
    end
    if (step_en) begin
      if (cw.pc_inc) begin
        arch_nxt.pc = arch_r.pc + 16'd1;
      end
      if (cw.sp_inc) begin
        arch_nxt.sp = arch_r.sp + 16'd1;
      end
      if (cw.sp_dec) begin
        arch_nxt.sp = arch_r.sp - 16'd1;
      end
      unique case (cw.op)
        ALU_LDA_MEM: begin
          a_new = rdata;
          a_upd = 1'b1;
        end
        ALU_LDA_C: begin
          a_new = arch_r.c;
          a_upd = 1'b1;
        end
        ALU_ADD: begin
          a_new = sum[7:0];
          a_upd = 1'b1;
          arch_nxt.carry = sum[8];
          arch_nxt.ovf = (arch_r.acc[7] ^ sum[7]) & (arch_r.c[7] ^ sum[7]);
        end
        ALU_LDC_MEM: arch_nxt.c = rdata;
        ALU_LO:      lo_nxt = rdata;
        ALU_JMP:     arch_nxt.pc = {rdata, lo_r};
        ALU_RD:      arch_nxt.rd = rdata;
        ALU_HALT:    arch_nxt.halted = 1'b1;
        ALU_UNK:     arch_nxt.unk = 1'b1;
        default:     ;
      endcase
      if (a_upd) begin
        arch_nxt.acc = a_new;
        arch_nxt.sign = a_new[7];
        arch_nxt.zero = (a_new == 8'h00);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r <= '{rd: 8'h00, acc: 8'h00, c: 8'h00, pc: 16'h0000, sp: SP_RESET,
                  carry: 1'b0, ovf: 1'b0, sign: 1'b0, zero: 1'b0,
                  halted: 1'b0, unk: 1'b0};
    end else begin
      arch_r <= arch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    if (start) begin
      addr_r <= cmd_address;
      wd_r <= cmd_wdata;
    end
  end

endmodule
